// ----- design/tst_pkg.sv -----
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants for the timer slot table
// Field widths, opcodes, result kinds and default sizes.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int MAX_SLOTS         = 16;
  localparam int DEF_SLOTS         = 16;
  localparam int DEF_TIME_BITS     = 32;

  localparam int OPCODE_W          = 2;
  localparam int INDEX_W           = 5;
  localparam int PERIOD_W          = 16;
  localparam int KIND_W            = 3;
  localparam int RES_SLOT_W        = 4;

  // slot_index, period_ticks, repeat_mode packed from bit 0, padded to bytes
  localparam int IN_TDATA_W        = 24;
  // result_slot, rearmed packed from bit 0, padded to a byte
  localparam int OUT_TDATA_W       = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGNED = 3'd0,
    KIND_OK       = 3'd1,
    KIND_REJECT   = 3'd2,
    KIND_EXPIRED  = 3'd3,
    KIND_NONE     = 3'd4
  } kind_t;

endpackage

// ----- design/tst_addsub.sv -----
// ----------------------------------------------------------------------------
// tst_addsub: shared time adder / subtractor
// Computes a + b or a - b modulo 2^W and flags a serial "has passed" result.
// ----------------------------------------------------------------------------
module tst_addsub #(
  parameter int W = 32
) (
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         passed
);

  logic [W-1:0] b_x;

  assign b_x    = sub ? ~op_b : op_b;
  assign sum    = op_a + b_x + W'(sub);
  // difference nonzero and in the lower half of the circle
  assign passed = (|sum) && !sum[W-1];

endmodule

// ----- design/timer_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// timer_slot_table_unit: table of timer slots driven by a tick count
// Create, delete, modify and tick requests on one stream; results on another.
// ----------------------------------------------------------------------------
// Delete: S_EMIT. Modify: S_ARM, S_EMIT. Create: free-slot scan, S_ARM, S_EMIT.
// Tick: S_TICK_INC, S_SCAN_CMP per slot, S_SCAN_REARM per repeating expiry, S_FLUSH;
// one slot per cycle, bar re-arms and output stalls, via the single adder/subtractor.
// Throughput: one request at a time; in_tready is high only between requests.
// Reset clears the valid bits, the tick count and the output register; slot
// deadline, period and repeat contents are undefined until armed.
module timer_slot_table_unit
  import tst_pkg::*;
#(
  parameter int SLOTS     = tst_pkg::DEF_SLOTS,
  parameter int TIME_BITS = tst_pkg::DEF_TIME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [4:0] slot_index, [20:5] period_ticks, [21] repeat_mode
  input  logic [tst_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [tst_pkg::OPCODE_W-1:0]    in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] result_slot, [4] rearmed
  output logic [tst_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] result_kind
  output logic [tst_pkg::KIND_W-1:0]      out_tuser,
  output logic                            out_tlast
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [INDEX_W:0]   SLOT_CNT  = (INDEX_W + 1)'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRT_SCAN,
    S_ARM,
    S_EMIT,
    S_TICK_INC,
    S_SCAN_CMP,
    S_SCAN_REARM,
    S_FLUSH
  } state_t;

  state_t                  state_r;
  logic [SLOT_W-1:0]       ptr_r;
  logic [SLOTS-1:0]        valid_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [PERIOD_W-1:0]     period_r;
  logic                    rep_r;
  kind_t                   kind_r;
  logic [RES_SLOT_W-1:0]   res_slot_r;
  logic                    pend_valid_r;
  logic [RES_SLOT_W-1:0]   pend_slot_r;
  logic                    pend_rearm_r;

  logic                    out_tvalid_r;
  kind_t                   out_kind_r;
  logic [RES_SLOT_W-1:0]   out_slot_r;
  logic                    out_rearm_r;
  logic                    out_last_r;

  logic [TIME_BITS-1:0]    deadline_r [SLOTS];
  logic [PERIOD_W-1:0]     slot_period_r [SLOTS];
  logic                    slot_repeat_r [SLOTS];

  logic [INDEX_W-1:0]      in_idx;
  logic [PERIOD_W-1:0]     in_period;
  logic                    in_rep;
  opcode_t                 in_op;
  logic                    in_fire;
  logic                    idx_ok;
  logic                    out_free;
  logic                    out_load;

  logic [TIME_BITS-1:0]    alu_b;
  logic                    alu_sub;
  logic [TIME_BITS-1:0]    alu_sum;
  logic                    alu_passed;
  logic                    hit;

  assign in_idx    = in_tdata[INDEX_W-1:0];
  assign in_period = in_tdata[INDEX_W +: PERIOD_W];
  assign in_rep    = in_tdata[INDEX_W + PERIOD_W];
  assign in_op     = opcode_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign idx_ok    = ({1'b0, in_idx} < SLOT_CNT);
  assign out_free  = !out_tvalid_r || out_tready;

  // operand A is always the tick count; B depends on the step
  always_comb begin
    alu_b   = TIME_BITS'(1);
    alu_sub = 1'b0;
    unique case (state_r)
      S_ARM:        alu_b = TIME_BITS'(period_r);
      S_SCAN_REARM: alu_b = TIME_BITS'(slot_period_r[ptr_r]);
      S_SCAN_CMP: begin
        alu_b   = deadline_r[ptr_r];
        alu_sub = 1'b1;
      end
      default:      alu_b = TIME_BITS'(1);
    endcase
  end

  tst_addsub #(
    .W (TIME_BITS)
  ) u_addsub (
    .op_a   (now_r),
    .op_b   (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .passed (alu_passed)
  );

  assign hit = valid_r[ptr_r] && alu_passed;

  // output register takes a new result in this cycle
  assign out_load = out_free &&
                    ((state_r == S_EMIT) || (state_r == S_FLUSH) ||
                     ((state_r == S_SCAN_CMP) && hit && pend_valid_r));

  always_ff @(posedge clk) begin
    if (state_r == S_ARM) begin
      deadline_r[ptr_r]    <= alu_sum;
      slot_period_r[ptr_r] <= period_r;
      slot_repeat_r[ptr_r] <= rep_r;
    end else if (state_r == S_SCAN_REARM) begin
      deadline_r[ptr_r]    <= alu_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ptr_r        <= '0;
      valid_r      <= '0;
      now_r        <= '0;
      period_r     <= '0;
      rep_r        <= 1'b0;
      kind_r       <= KIND_OK;
      res_slot_r   <= '0;
      pend_valid_r <= 1'b0;
      pend_slot_r  <= '0;
      pend_rearm_r <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_kind_r   <= KIND_OK;
      out_slot_r   <= '0;
      out_rearm_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            period_r   <= in_period;
            rep_r      <= in_rep;
            res_slot_r <= '0;
            unique case (in_op)
              OP_CREATE: begin
                ptr_r   <= '0;
                state_r <= S_CRT_SCAN;
              end
              OP_DELETE: begin
                if (idx_ok) begin
                  valid_r[in_idx[SLOT_W-1:0]] <= 1'b0;
                  kind_r <= KIND_OK;
                end else begin
                  kind_r <= KIND_REJECT;
                end
                state_r <= S_EMIT;
              end
              OP_MODIFY: begin
                ptr_r <= in_idx[SLOT_W-1:0];
                if (idx_ok) begin
                  kind_r  <= KIND_OK;
                  state_r <= S_ARM;
                end else begin
                  kind_r  <= KIND_REJECT;
                  state_r <= S_EMIT;
                end
              end
              OP_TICK: begin
                state_r <= S_TICK_INC;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_CRT_SCAN: begin
          if (!valid_r[ptr_r]) begin
            kind_r     <= KIND_ASSIGNED;
            res_slot_r <= RES_SLOT_W'(ptr_r);
            state_r    <= S_ARM;
          end else if (ptr_r == LAST_SLOT) begin
            kind_r  <= KIND_REJECT;
            state_r <= S_EMIT;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_ARM: begin
          valid_r[ptr_r] <= 1'b1;
          state_r        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind_r   <= kind_r;
            out_slot_r   <= res_slot_r;
            out_rearm_r  <= 1'b0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_TICK_INC: begin
          now_r        <= alu_sum;
          ptr_r        <= '0;
          pend_valid_r <= 1'b0;
          state_r      <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (!hit || !pend_valid_r || out_free) begin
            if (hit) begin
              // previous expiry is known not to be the last one
              if (pend_valid_r) begin
                out_kind_r   <= KIND_EXPIRED;
                out_slot_r   <= pend_slot_r;
                out_rearm_r  <= pend_rearm_r;
                out_last_r   <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_slot_r  <= RES_SLOT_W'(ptr_r);
              pend_rearm_r <= slot_repeat_r[ptr_r];
            end
            if (hit && slot_repeat_r[ptr_r]) begin
              state_r <= S_SCAN_REARM;
            end else begin
              if (hit) begin
                valid_r[ptr_r] <= 1'b0;
              end
              if (ptr_r == LAST_SLOT) begin
                state_r <= S_FLUSH;
              end else begin
                ptr_r <= ptr_r + 1'b1;
              end
            end
          end
        end
        S_SCAN_REARM: begin
          if (ptr_r == LAST_SLOT) begin
            state_r <= S_FLUSH;
          end else begin
            ptr_r   <= ptr_r + 1'b1;
            state_r <= S_SCAN_CMP;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_last_r   <= 1'b1;
            if (pend_valid_r) begin
              out_kind_r  <= KIND_EXPIRED;
              out_slot_r  <= pend_slot_r;
              out_rearm_r <= pend_rearm_r;
            end else begin
              out_kind_r  <= KIND_NONE;
              out_slot_r  <= '0;
              out_rearm_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_SLOT_W - 1){1'b0}}, out_rearm_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- bench/timer_slot_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_slot_table_checker: result predictor and scoreboard
// Watches both streams of timer_slot_table_unit. Each accepted request runs
// through a local model of the slot table, and the expected results queue up
// in order. Each accepted result is checked field by field against the oldest
// queued one.
// ----------------------------------------------------------------------------
module timer_slot_table_checker
  import tst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic [OPCODE_W-1:0]     in_tuser,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_TDATA_W-1:0]  out_tdata,
  input  logic [KIND_W-1:0]       out_tuser,
  input  logic                    out_tlast,
  output int                      fail_count,
  output int                      pending
);

  localparam int SLOTS     = DEF_SLOTS;
  localparam int TIME_BITS = DEF_TIME_BITS;

  typedef struct packed {
    kind_t                 kind;
    logic [RES_SLOT_W-1:0] slot;
    logic                  rearmed;
    logic                  last;
  } timer_result_t;

  // local copy of the slot table
  logic                 tbl_valid    [SLOTS];
  logic [TIME_BITS-1:0] tbl_deadline [SLOTS];
  logic [PERIOD_W-1:0]  tbl_period   [SLOTS];
  logic                 tbl_repeat   [SLOTS];
  logic [TIME_BITS-1:0] now_ticks;

  timer_result_t expected_results[$];
  timer_result_t want;
  int            mismatch_count = 0;
  int            pending_count  = 0;

  assign fail_count = mismatch_count;
  assign pending    = pending_count;

  initial begin
    now_ticks = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_valid[s] = 1'b0;
    end
  end

  function automatic timer_result_t make_result(kind_t kind, int slot, logic rearmed,
                                                logic last);
    timer_result_t r;
    r.kind    = kind;
    r.slot    = slot[RES_SLOT_W-1:0];
    r.rearmed = rearmed;
    r.last    = last;
    return r;
  endfunction

  task automatic arm_timer(int s, logic [PERIOD_W-1:0] per, logic rep);
    tbl_valid[s]    = 1'b1;
    tbl_period[s]   = per;
    tbl_repeat[s]   = rep;
    tbl_deadline[s] = now_ticks + TIME_BITS'(per);
  endtask

  // Apply one request to the table and queue the results it must produce.
  task automatic apply_timer_request(opcode_t op, logic [INDEX_W-1:0] idx,
                                     logic [PERIOD_W-1:0] per, logic rep);
    int                   free_slot;
    int                   hits;
    int                   last_pos;
    logic [TIME_BITS-1:0] age;
    free_slot = -1;
    hits      = 0;
    case (op)
      OP_CREATE: begin
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (!tbl_valid[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          expected_results.push_back(make_result(KIND_REJECT, 0, 1'b0, 1'b1));
        end else begin
          arm_timer(free_slot, per, rep);
          expected_results.push_back(make_result(KIND_ASSIGNED, free_slot, 1'b0, 1'b1));
        end
      end
      OP_DELETE, OP_MODIFY: begin
        if (idx >= SLOTS) begin
          expected_results.push_back(make_result(KIND_REJECT, 0, 1'b0, 1'b1));
        end else begin
          if (op == OP_DELETE) tbl_valid[idx] = 1'b0;
          else arm_timer(int'(idx), per, rep);
          expected_results.push_back(make_result(KIND_OK, 0, 1'b0, 1'b1));
        end
      end
      default: begin
        now_ticks = now_ticks + 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
          age = now_ticks - tbl_deadline[s];
          // serial compare: passed when the age is nonzero and in the lower half
          if (tbl_valid[s] && age != '0 && !age[TIME_BITS-1]) begin
            if (tbl_repeat[s]) tbl_deadline[s] = now_ticks + TIME_BITS'(tbl_period[s]);
            else tbl_valid[s] = 1'b0;
            expected_results.push_back(make_result(KIND_EXPIRED, s, tbl_repeat[s], 1'b0));
            hits++;
          end
        end
        if (hits == 0) begin
          expected_results.push_back(make_result(KIND_NONE, 0, 1'b0, 1'b1));
        end else begin
          last_pos = expected_results.size() - 1;
          expected_results[last_pos].last = 1'b1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d", out_tuser, out_tdata[3:0]);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[3:0] !== want.slot) begin
            $error("result_slot: expected %0d, got %0d", want.slot, out_tdata[3:0]);
            mismatch_count++;
          end
          if (out_tdata[4] !== want.rearmed) begin
            $error("rearmed: expected %0d, got %0d", want.rearmed, out_tdata[4]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_timer_request(opcode_t'(in_tuser), in_tdata[4:0], in_tdata[20:5], in_tdata[21]);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

// ----- bench/timer_slot_table_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_slot_table_unit_tb: testbench top for the timer slot table
// Drives a directed request sequence (expiry, full table, bad indexes, period
// extremes) and then random requests under several sender and receiver
// stall patterns; the checker module scores every result.
// ----------------------------------------------------------------------------
module timer_slot_table_unit_tb;
  import tst_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OPCODE_W-1:0]    in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  timer_slot_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  timer_slot_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(opcode_t op, logic [INDEX_W-1:0] idx,
                              logic [PERIOD_W-1:0] per, logic rep);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {2'b00, rep, per, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic random_request();
    opcode_t             op;
    logic [INDEX_W-1:0]  idx;
    logic [PERIOD_W-1:0] per;
    int                  pick;
    pick = int'($urandom_range(99));
    if (pick < 35) op = OP_TICK;
    else if (pick < 62) op = OP_CREATE;
    else if (pick < 80) op = OP_DELETE;
    else op = OP_MODIFY;
    // mostly valid slots, now and then an out-of-range index
    if ($urandom_range(9) == 0) idx = INDEX_W'($urandom_range(31, 16));
    else idx = INDEX_W'($urandom_range(15, 0));
    // short periods keep expiries frequent; some full-range ones
    if ($urandom_range(99) < 80) per = PERIOD_W'($urandom_range(6));
    else per = PERIOD_W'($urandom());
    push_request(op, idx, per, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, no idling
    push_request(OP_TICK, 5'd0, 16'd0, 1'b0);         // nothing expired
    push_request(OP_CREATE, 5'd0, 16'd0, 1'b0);       // slot 0, zero period
    push_request(OP_TICK, 5'd31, 16'hFFFF, 1'b1);     // one-shot expiry
    push_request(OP_CREATE, 5'd0, 16'hFFFF, 1'b1);    // longest period
    push_request(OP_MODIFY, 5'd15, 16'd1, 1'b1);      // arm a free slot
    push_request(OP_DELETE, 5'd16, 16'd0, 1'b0);      // first bad index
    push_request(OP_MODIFY, 5'd31, 16'hFFFF, 1'b1);   // last bad index
    push_request(OP_DELETE, 5'd7, 16'd0, 1'b0);       // delete of a free slot
    for (int i = 1; i <= 14; i++) begin
      push_request(OP_CREATE, 5'd0, 16'd0, i[0]);
    end
    push_request(OP_CREATE, 5'd0, 16'd5, 1'b1);       // table full
    push_request(OP_TICK, 5'd0, 16'd0, 1'b0);         // fourteen expiries
    push_request(OP_TICK, 5'd0, 16'd0, 1'b0);         // re-armed ones again
    push_request(OP_DELETE, 5'd0, 16'd0, 1'b0);       // delete of a valid slot
    push_request(OP_MODIFY, 5'd15, 16'd0, 1'b0);      // re-arm a valid slot

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      repeat (71) random_request();
    end
    in_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[timer_slot_table_unit] OK");
    end else begin
      $display("[timer_slot_table_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[timer_slot_table_unit] ERROR");
    $finish;
  end

endmodule
